### rtl/core/button_gesture_mode_control_macros.svh
// Assertion helpers used by the top-level gesture control module
`ifndef BUTTON_GESTURE_MODE_CONTROL_MACROS_SVH
`define BUTTON_GESTURE_MODE_CONTROL_MACROS_SVH

// Same-cycle implication, checked outside reset
`define BGM_ASSERT_SAME(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("%m: same-cycle check failed");

// Next-cycle implication, checked outside reset
`define BGM_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("%m: next-cycle check failed");

`endif

### rtl/core/bgm_pkg.sv
package bgm_pkg;

    // Configuration register geometry
    localparam int CFG_W  = 24;
    localparam int ADDR_W = 4;
    localparam int DATA_W = 32;

    // Register indexes (byte address / 4)
    localparam logic [1:0] REG_DEBOUNCE   = 2'd0;
    localparam logic [1:0] REG_LONG_PRESS = 2'd1;
    localparam logic [1:0] REG_CLICK_WIN  = 2'd2;
    localparam logic [1:0] REG_SPEED_IDLE = 2'd3;

    // Register reset values
    localparam logic [CFG_W-1:0] DEBOUNCE_RST   = 24'd50000;
    localparam logic [CFG_W-1:0] LONG_PRESS_RST = 24'd5000000;
    localparam logic [CFG_W-1:0] CLICK_WIN_RST  = 24'd350000;
    localparam logic [CFG_W-1:0] SPEED_IDLE_RST = 24'd10000000;

    // Mode limits
    localparam logic [4:0] SPEED_MIN     = 5'd2;
    localparam logic [4:0] SPEED_MAX     = 5'd30;
    localparam logic [1:0] CLICK_MAX     = 2'd3;
    localparam logic [1:0] PROTOCOL_LAST = 2'd2;

    typedef enum logic [1:0] {
        ACT_NONE     = 2'd0,
        ACT_PROTOCOL = 2'd1,
        ACT_SPEED    = 2'd2,
        ACT_DIAG     = 2'd3
    } t_action;

    typedef struct packed {
        logic [CFG_W-1:0] debounce_ticks;
        logic [CFG_W-1:0] long_press_ticks;
        logic [CFG_W-1:0] click_window_ticks;
        logic [CFG_W-1:0] speed_idle_ticks;
    } t_cfg;

    typedef struct packed {
        logic [1:0] protocol_select;
        logic [4:0] speed_tenths;
        logic       speed_mode;
        logic       diag_mode;
        logic       save_request;
        t_action    gesture_action;
    } t_result;

endpackage

### rtl/core/bgm_cfg.sv
module bgm_cfg (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       psel,
    input  logic                       penable,
    input  logic                       pwrite,
    input  logic [bgm_pkg::ADDR_W-1:0] paddr,
    input  logic [bgm_pkg::DATA_W-1:0] pwdata,
    output logic [bgm_pkg::DATA_W-1:0] prdata,
    output logic                       pready,
    output bgm_pkg::t_cfg              o_cfg
);
    import bgm_pkg::*;

    t_cfg       r_cfg;
    logic       wr_en;
    logic [1:0] reg_idx;

    assign pready  = 1'b1;
    assign wr_en   = psel & penable & pwrite;
    assign reg_idx = paddr[3:2];
    assign o_cfg   = r_cfg;

    // Register writes on the access phase
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.debounce_ticks     <= DEBOUNCE_RST;
            r_cfg.long_press_ticks   <= LONG_PRESS_RST;
            r_cfg.click_window_ticks <= CLICK_WIN_RST;
            r_cfg.speed_idle_ticks   <= SPEED_IDLE_RST;
        end else if (wr_en) begin
            unique case (reg_idx)
                REG_DEBOUNCE:   r_cfg.debounce_ticks     <= pwdata[CFG_W-1:0];
                REG_LONG_PRESS: r_cfg.long_press_ticks   <= pwdata[CFG_W-1:0];
                REG_CLICK_WIN:  r_cfg.click_window_ticks <= pwdata[CFG_W-1:0];
                REG_SPEED_IDLE: r_cfg.speed_idle_ticks   <= pwdata[CFG_W-1:0];
                default:        r_cfg                    <= r_cfg;
            endcase
        end
    end

    // Read-back mux
    always_comb begin
        unique case (reg_idx)
            REG_DEBOUNCE:   prdata = DATA_W'(r_cfg.debounce_ticks);
            REG_LONG_PRESS: prdata = DATA_W'(r_cfg.long_press_ticks);
            REG_CLICK_WIN:  prdata = DATA_W'(r_cfg.click_window_ticks);
            REG_SPEED_IDLE: prdata = DATA_W'(r_cfg.speed_idle_ticks);
            default:        prdata = '0;
        endcase
    end

endmodule

### rtl/core/bgm_core.sv
module bgm_core #(
    parameter int TIMER_WIDTH = 24
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_step,
    input  logic             i_down,
    input  bgm_pkg::t_cfg    i_cfg,
    output bgm_pkg::t_result o_result
);
    import bgm_pkg::*;

    localparam int CMP_W = (TIMER_WIDTH > CFG_W) ? TIMER_WIDTH : CFG_W;
    localparam logic [TIMER_WIDTH-1:0] TMAX = {TIMER_WIDTH{1'b1}};

    // Gesture state
    logic                   r_held, n_held;
    logic                   r_long_done, n_long_done;
    logic [TIMER_WIDTH-1:0] r_since_edge, n_since_edge;
    logic [TIMER_WIDTH-1:0] r_held_for, n_held_for;
    logic [1:0]             r_clicks, n_clicks;
    logic [TIMER_WIDTH-1:0] r_since_click, n_since_click;
    logic                   r_speed_mode, n_speed_mode;
    logic [TIMER_WIDTH-1:0] r_since_speed, n_since_speed;
    logic                   r_diag_mode, n_diag_mode;
    logic [1:0]             r_protocol, n_protocol;
    logic [4:0]             r_speed, n_speed;

    logic [TIMER_WIDTH-1:0] inc_edge, inc_held, inc_click, inc_speed;
    logic [4:0]             speed_clamped, speed_stepped;
    logic [1:0]             protocol_next;
    logic                   save;
    t_action                action;

    // Saturating tick counters
    assign inc_edge  = (r_since_edge  == TMAX) ? TMAX : r_since_edge  + 1'b1;
    assign inc_held  = (r_held_for    == TMAX) ? TMAX : r_held_for    + 1'b1;
    assign inc_click = (r_since_click == TMAX) ? TMAX : r_since_click + 1'b1;
    assign inc_speed = (r_since_speed == TMAX) ? TMAX : r_since_speed + 1'b1;

    // Speed step with clamp into range, then wrap
    assign speed_clamped = (r_speed < SPEED_MIN) ? SPEED_MIN :
                           (r_speed > SPEED_MAX) ? SPEED_MAX : r_speed;
    assign speed_stepped = (speed_clamped == SPEED_MAX) ? SPEED_MIN : speed_clamped + 5'd1;

    // Protocol advances modulo three
    assign protocol_next = (r_protocol == PROTOCOL_LAST) ? 2'd0 :
                           (r_protocol == 2'd3)          ? 2'd1 : r_protocol + 2'd1;

    // One tick of the gesture logic
    always_comb begin
        n_held        = r_held;
        n_long_done   = r_long_done;
        n_since_edge  = inc_edge;
        n_held_for    = inc_held;
        n_clicks      = r_clicks;
        n_since_click = inc_click;
        n_speed_mode  = r_speed_mode;
        n_since_speed = inc_speed;
        n_diag_mode   = r_diag_mode;
        n_protocol    = r_protocol;
        n_speed       = r_speed;
        save          = 1'b0;
        action        = ACT_NONE;

        // press edge
        if (i_down && !r_held && (CMP_W'(inc_edge) > CMP_W'(i_cfg.debounce_ticks))) begin
            n_since_edge = '0;
            n_held       = 1'b1;
            n_long_done  = 1'b0;
            n_held_for   = '0;
        end

        // long press
        if (i_down && n_held && !n_long_done &&
            (CMP_W'(n_held_for) >= CMP_W'(i_cfg.long_press_ticks))) begin
            n_long_done  = 1'b1;
            n_clicks     = 2'd0;
            n_speed_mode = 1'b0;
            n_diag_mode  = 1'b0;
            save         = 1'b1;
        end

        // release edge
        if (!i_down && n_held && (CMP_W'(n_since_edge) > CMP_W'(i_cfg.debounce_ticks))) begin
            n_since_edge = '0;
            n_held       = 1'b0;
            if (!n_long_done) begin
                if (n_speed_mode) begin
                    n_speed       = speed_stepped;
                    n_since_speed = '0;
                end else begin
                    if ((n_clicks == 2'd0) ||
                        (CMP_W'(n_since_click) > CMP_W'(i_cfg.click_window_ticks))) begin
                        n_clicks = 2'd1;
                    end else if (n_clicks < CLICK_MAX) begin
                        n_clicks = n_clicks + 2'd1;
                    end
                    n_since_click = '0;
                end
            end
        end

        // click window closes
        if (!n_speed_mode && (n_clicks != 2'd0) &&
            (CMP_W'(n_since_click) > CMP_W'(i_cfg.click_window_ticks))) begin
            case (n_clicks)
                2'd1: begin
                    n_diag_mode = 1'b0;
                    n_protocol  = protocol_next;
                    action      = ACT_PROTOCOL;
                end
                2'd2: begin
                    n_diag_mode   = 1'b0;
                    n_speed_mode  = 1'b1;
                    n_since_speed = '0;
                    action        = ACT_SPEED;
                end
                default: begin
                    n_speed_mode = 1'b0;
                    n_diag_mode  = !n_diag_mode;
                    action       = ACT_DIAG;
                end
            endcase
            n_clicks = 2'd0;
        end

        // speed mode idle timeout
        if (n_speed_mode && (CMP_W'(n_since_speed) > CMP_W'(i_cfg.speed_idle_ticks))) begin
            n_speed_mode = 1'b0;
        end
    end

    // State update, one tick per transaction
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_held        <= 1'b0;
            r_long_done   <= 1'b0;
            r_since_edge  <= TMAX;
            r_held_for    <= '0;
            r_clicks      <= 2'd0;
            r_since_click <= '0;
            r_speed_mode  <= 1'b0;
            r_since_speed <= '0;
            r_diag_mode   <= 1'b0;
            r_protocol    <= 2'd0;
            r_speed       <= SPEED_MIN;
        end else if (i_step) begin
            r_held        <= n_held;
            r_long_done   <= n_long_done;
            r_since_edge  <= n_since_edge;
            r_held_for    <= n_held_for;
            r_clicks      <= n_clicks;
            r_since_click <= n_since_click;
            r_speed_mode  <= n_speed_mode;
            r_since_speed <= n_since_speed;
            r_diag_mode   <= n_diag_mode;
            r_protocol    <= n_protocol;
            r_speed       <= n_speed;
        end
    end

    // Result reflects the state after this tick
    assign o_result.protocol_select = n_protocol;
    assign o_result.speed_tenths    = n_speed;
    assign o_result.speed_mode      = n_speed_mode;
    assign o_result.diag_mode       = n_diag_mode;
    assign o_result.save_request    = save;
    assign o_result.gesture_action  = action;

endmodule

### rtl/core/button_gesture_mode_control.sv
// Push-button gesture and mode control. Each input transaction carries one
// sampled button level and produces exactly one result transaction holding
// the protocol, speed, mode flags, save pulse and gesture action after that
// tick. A transaction is taken every clock cycle when the output side keeps
// up; the input register takes the level on acceptance and the result
// register is loaded from it once it has room, and the result is presented
// from there. While a result waits, a held input stays in the input register
// and input ready drops. The gesture state advances once per transaction.
// Timing registers sit on the APB port at byte addresses 0x0, 0x4, 0x8, 0xC
// and should only be written while no transaction is in flight. There is no
// clearing pass after reset.
module button_gesture_mode_control #(
    parameter int TIMER_WIDTH = 24
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    // input channel
    input  logic                       i_in_valid,
    output logic                       o_in_ready,
    input  logic                       i_button_down,
    // result channel
    output logic                       o_out_valid,
    input  logic                       i_out_ready,
    output logic [1:0]                 o_protocol_select,
    output logic [4:0]                 o_speed_tenths,
    output logic                       o_speed_mode,
    output logic                       o_diag_mode,
    output logic                       o_save_request,
    output logic [1:0]                 o_gesture_action,
    // APB configuration port
    input  logic                       psel,
    input  logic                       penable,
    input  logic                       pwrite,
    input  logic [bgm_pkg::ADDR_W-1:0] paddr,
    input  logic [bgm_pkg::DATA_W-1:0] pwdata,
    output logic [bgm_pkg::DATA_W-1:0] prdata,
    output logic                       pready
);
    import bgm_pkg::*;

`include "button_gesture_mode_control_macros.svh"

    t_cfg    cfg;
    t_result step_result;
    t_result r_out;
    logic    r_in_valid;
    logic    r_in_down;
    logic    r_out_valid;
    logic    advance;

    bgm_cfg u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (cfg)
    );

    // Move the held transaction into the result register when it has room
    assign advance    = r_in_valid & (~r_out_valid | i_out_ready);
    assign o_in_ready = ~r_in_valid | advance;

    bgm_core #(
        .TIMER_WIDTH (TIMER_WIDTH)
    ) u_core (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_step   (advance),
        .i_down   (r_in_down),
        .i_cfg    (cfg),
        .o_result (step_result)
    );

    // Input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_in_ready) begin
            r_in_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_in_ready && i_in_valid) begin
            r_in_down <= i_button_down;
        end
    end

    // Result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_out <= step_result;
        end
    end

    assign o_out_valid       = r_out_valid;
    assign o_protocol_select = r_out.protocol_select;
    assign o_speed_tenths    = r_out.speed_tenths;
    assign o_speed_mode      = r_out.speed_mode;
    assign o_diag_mode       = r_out.diag_mode;
    assign o_save_request    = r_out.save_request;
    assign o_gesture_action  = r_out.gesture_action;

    // Checks
    `BGM_ASSERT_SAME(a_save_clears_modes, i_clk, i_rst_n, o_out_valid && o_save_request, !o_speed_mode && !o_diag_mode && (o_gesture_action == ACT_NONE))
    `BGM_ASSERT_SAME(a_speed_in_range, i_clk, i_rst_n, o_out_valid, (o_speed_tenths >= SPEED_MIN) && (o_speed_tenths <= SPEED_MAX))
    `BGM_ASSERT_SAME(a_speed_entry, i_clk, i_rst_n, o_out_valid && (o_gesture_action == ACT_SPEED), o_speed_mode && !o_diag_mode)
    `BGM_ASSERT_NEXT(a_stall_blocks_input, i_clk, i_rst_n, r_in_valid && r_out_valid && !i_out_ready, r_in_valid && r_out_valid)

endmodule
